/* rtl/sss_pkg.sv */
`default_nettype none

package sss_pkg;

    localparam int PWM_STEPS  = 4096;
    localparam int STEP_TOP   = (PWM_STEPS - 1 > 4095) ? 4095 : PWM_STEPS - 1;
    localparam int STEP_W     = 12;
    localparam int POS_W      = 16;
    localparam int CH_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // |pos - lo| * |hi_out - lo_out| fits 28 bits
    localparam int DIV_BITS   = 28;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);

    localparam logic [STEP_W-1:0] RESET_MID       = 12'd307;
    localparam logic [STEP_W-1:0] RESET_MIN_STEPS = 12'd204;
    localparam logic [STEP_W-1:0] RESET_MAX_STEPS = 12'd409;
    localparam logic [POS_W-1:0]  RESET_POS_LOW   = 16'd0;
    localparam logic [POS_W-1:0]  RESET_POS_HIGH  = 16'd2000;

    // floor(x / 10) == (x * 52429) >> 19 for every x below 2^16
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [STEP_W-1:0] PROP_SNAP = 12'd10;
    localparam logic [STEP_W-1:0] LIN_SNAP  = 12'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_STEPS     = 4'd0,
        REG_MAX_STEPS     = 4'd1,
        REG_REVERSED      = 4'd2,
        REG_SMOOTHED      = 4'd3,
        REG_LINEAR_MODE   = 4'd4,
        REG_POSITION_LOW  = 4'd5,
        REG_POSITION_HIGH = 4'd6,
        REG_CHANNEL       = 4'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_TICK,
        ST_PROP
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_step;
        logic set_done;
        logic tick_done;
        logic prop_sum;
        logic prop_done;
    } cmd_t;

    typedef struct packed {
        logic tick_now;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/sss_ctrl.sv */
`default_nettype none

module sss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          mode,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire sss_pkg::stat_t stat,
    output sss_pkg::cmd_t      cmd
);

    sss_pkg::state_t state_reg, state_next;
    logic [sss_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sss_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mode ? sss_pkg::ST_TICK : sss_pkg::ST_MUL;
                end
            end
            sss_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = sss_pkg::ST_DIV;
            end
            sss_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sss_pkg::DIV_CNT_W'(sss_pkg::DIV_BITS - 1))
                begin
                    state_next = sss_pkg::ST_FIX;
                end
            end
            sss_pkg::ST_FIX:
            begin
                if (out_free)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = sss_pkg::ST_IDLE;
                end
            end
            sss_pkg::ST_TICK:
            begin
                if (!stat.tick_now)
                begin
                    cmd.prop_sum = 1'b1;
                    state_next   = sss_pkg::ST_PROP;
                end
                else if (out_free)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = sss_pkg::ST_IDLE;
                end
            end
            sss_pkg::ST_PROP:
            begin
                if (out_free)
                begin
                    cmd.prop_done = 1'b1;
                    state_next    = sss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sss_pkg::ST_IDLE;
            end
        endcase
    end

    assign load_out = cmd.set_done || cmd.tick_done || cmd.prop_done;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/sss_datapath.sv */
`default_nettype none

module sss_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sss_pkg::cmd_t                    cmd,
    output sss_pkg::stat_t                        stat,
    input  wire logic                             cfg_we,
    input  wire logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [sss_pkg::POS_W-1:0]        position,
    output logic                                  pwm_write,
    output logic [sss_pkg::CH_W-1:0]              pwm_channel,
    output logic [sss_pkg::STEP_W-1:0]            pwm_steps,
    output logic                                  settled
);

    localparam int SW = sss_pkg::STEP_W;
    localparam int PW = sss_pkg::POS_W;
    localparam int QW = sss_pkg::DIV_BITS;

    // configuration
    logic [SW-1:0]           min_steps_reg, max_steps_reg;
    logic                    reversed_reg, smoothed_reg, linear_reg;
    logic [PW-1:0]           pos_low_reg, pos_high_reg;
    logic [sss_pkg::CH_W-1:0] channel_reg;

    // state
    logic [SW-1:0] target_reg, target_next;
    logic [SW-1:0] current_reg, current_next;

    // working registers
    logic [PW-1:0] pos_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] den_reg;
    logic          neg_reg;
    logic          zero_rng_reg;
    logic [15:0]   sum_reg;

    // result register
    logic          wr_reg, wr_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic          settled_reg, settled_next;

    // mapping
    logic [SW-1:0]  out_lo, out_hi;
    logic [PW:0]    d_pos, d_rng;
    logic [SW:0]    d_out;
    logic [PW-1:0]  mag_pos, mag_rng;
    logic [SW-1:0]  mag_out;
    logic [QW-1:0]  prod;
    logic [PW:0]    rem_sh;
    logic           fits;
    logic [QW:0]    q_s;
    logic [QW+1:0]  v_s;
    logic [SW-1:0]  mapped;

    // ticks
    logic [SW-1:0]  diff;
    logic [SW-1:0]  lin_n;
    logic [15:0]    blend;
    logic [31:0]    recip;
    logic [SW-1:0]  prop_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_steps_reg <= sss_pkg::RESET_MIN_STEPS;
            max_steps_reg <= sss_pkg::RESET_MAX_STEPS;
            reversed_reg  <= 1'b0;
            smoothed_reg  <= 1'b1;
            linear_reg    <= 1'b1;
            pos_low_reg   <= sss_pkg::RESET_POS_LOW;
            pos_high_reg  <= sss_pkg::RESET_POS_HIGH;
            channel_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (sss_pkg::cfg_idx_t'(cfg_index))
                sss_pkg::REG_MIN_STEPS:     min_steps_reg <= cfg_data[SW-1:0];
                sss_pkg::REG_MAX_STEPS:     max_steps_reg <= cfg_data[SW-1:0];
                sss_pkg::REG_REVERSED:      reversed_reg  <= cfg_data[0];
                sss_pkg::REG_SMOOTHED:      smoothed_reg  <= cfg_data[0];
                sss_pkg::REG_LINEAR_MODE:   linear_reg    <= cfg_data[0];
                sss_pkg::REG_POSITION_LOW:  pos_low_reg   <= cfg_data[PW-1:0];
                sss_pkg::REG_POSITION_HIGH: pos_high_reg  <= cfg_data[PW-1:0];
                sss_pkg::REG_CHANNEL:       channel_reg   <= cfg_data[sss_pkg::CH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= sss_pkg::RESET_MID;
            current_reg <= sss_pkg::RESET_MID;
        end
        else
        begin
            target_reg  <= target_next;
            current_reg <= current_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg <= position;
        end
        if (cmd.mul)
        begin
            den_reg      <= mag_rng;
            neg_reg      <= d_pos[PW] ^ d_out[SW] ^ d_rng[PW];
            zero_rng_reg <= (pos_low_reg == pos_high_reg);
        end
        if (cmd.prop_sum)
        begin
            sum_reg <= blend;
        end
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        wr_reg      <= wr_next;
        steps_reg   <= steps_next;
        settled_reg <= settled_next;
    end

    // signed differences, then magnitudes for the unsigned divider
    assign out_lo  = reversed_reg ? max_steps_reg : min_steps_reg;
    assign out_hi  = reversed_reg ? min_steps_reg : max_steps_reg;
    assign d_pos   = {1'b0, pos_reg} - {1'b0, pos_low_reg};
    assign d_rng   = {1'b0, pos_high_reg} - {1'b0, pos_low_reg};
    assign d_out   = {1'b0, out_hi} - {1'b0, out_lo};
    assign mag_pos = d_pos[PW] ? PW'(-d_pos) : d_pos[PW-1:0];
    assign mag_rng = d_rng[PW] ? PW'(-d_rng) : d_rng[PW-1:0];
    assign mag_out = d_out[SW] ? SW'(-d_out) : d_out[SW-1:0];
    assign prod    = QW'(mag_pos) * QW'(mag_out);

    // restoring division, one quotient bit a beat of the counter
    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.mul)
        begin
            quo_next = prod;
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[QW-2:0], fits};
            rem_next = fits ? PW'(rem_sh - {1'b0, den_reg}) : rem_sh[PW-1:0];
        end
    end

    // truncation toward zero: negate the magnitude quotient, then add the offset
    assign q_s = neg_reg ? (QW+1)'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
    assign v_s = {q_s[QW], q_s} + (QW+2)'({1'b0, out_lo});

    always_comb
    begin
        if (zero_rng_reg)
        begin
            mapped = out_lo;
        end
        else if (v_s[QW+1])
        begin
            mapped = '0;
        end
        else if (v_s > (QW+2)'(sss_pkg::STEP_TOP))
        begin
            mapped = SW'(sss_pkg::STEP_TOP);
        end
        else
        begin
            mapped = v_s[SW-1:0];
        end
    end

    assign diff  = (target_reg > current_reg) ? target_reg - current_reg
                                              : current_reg - target_reg;
    assign lin_n = (diff > sss_pkg::LIN_SNAP)
                 ? ((current_reg < target_reg) ? current_reg + 1'b1 : current_reg - 1'b1)
                 : target_reg;
    assign blend = 16'(target_reg) + 16'({current_reg, 3'b000}) + 16'(current_reg);
    assign recip = sum_reg * sss_pkg::RECIP_TEN;
    assign prop_n = recip[sss_pkg::RECIP_SHIFT +: SW];

    assign stat.tick_now = !smoothed_reg || (target_reg == current_reg) || linear_reg
                         || (diff < sss_pkg::PROP_SNAP);

    always_comb
    begin
        target_next  = target_reg;
        current_next = current_reg;
        wr_next      = wr_reg;
        steps_next   = steps_reg;
        settled_next = settled_reg;
        if (cmd.set_done)
        begin
            settled_next = 1'b0;
            if (smoothed_reg)
            begin
                target_next = mapped;
                wr_next     = 1'b0;
                steps_next  = '0;
            end
            else
            begin
                wr_next    = 1'b1;
                steps_next = mapped;
            end
        end
        else if (cmd.tick_done)
        begin
            if (!smoothed_reg || (target_reg == current_reg))
            begin
                wr_next      = 1'b0;
                steps_next   = '0;
                settled_next = 1'b1;
            end
            else
            begin
                // linear step, or proportional snap when close
                current_next = linear_reg ? lin_n : target_reg;
                wr_next      = 1'b1;
                steps_next   = linear_reg ? lin_n : target_reg;
                settled_next = 1'b0;
            end
        end
        else if (cmd.prop_done)
        begin
            current_next = prop_n;
            wr_next      = 1'b1;
            steps_next   = prop_n;
            settled_next = 1'b0;
        end
    end

    assign pwm_write   = wr_reg;
    assign pwm_channel = channel_reg;
    assign pwm_steps   = steps_reg;
    assign settled     = settled_reg;

endmodule

`default_nettype wire

/* rtl/servo_slew_smoother.sv */
// Set item: result computed by the 28-step restoring divider, through ST_MUL, ST_DIV and ST_FIX.
// Tick item: result from ST_TICK, or via ST_PROP in proportional mode (blend registered, scaled by 1/10).
// One item at a time: the next input beat is taken only once the last result is loaded;
// a new item is taken while the previous result still waits.
// rst_n is asynchronous, active low: registers return to their defaults and
// target and current steps to the midpoint 307; no result is pending.
`default_nettype none

module servo_slew_smoother (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            mode,
    input  wire logic [sss_pkg::POS_W-1:0]       position,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 pwm_write,
    output logic [sss_pkg::CH_W-1:0]             pwm_channel,
    output logic [sss_pkg::STEP_W-1:0]           pwm_steps,
    output logic                                 settled,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sss_pkg::cmd_t  cmd;
    sss_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    sss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sss_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .position    (position),
        .pwm_write   (pwm_write),
        .pwm_channel (pwm_channel),
        .pwm_steps   (pwm_steps),
        .settled     (settled)
    );

endmodule

`default_nettype wire

/* rtl/sss_checker.sv */
`default_nettype none

module sss_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic                            pwm_write,
    input wire logic [sss_pkg::STEP_W-1:0]      pwm_steps,
    input wire logic                            settled
);

    // one item in flight: a beat in closes the input until its result is loaded
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    a_settled_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && settled) |-> !pwm_write)
        else $error("settled result carries a write");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pwm_write) |-> (pwm_steps == '0))
        else $error("step count without a write");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before its beat");

endmodule

bind servo_slew_smoother sss_checker u_sss_checker (.*);

`default_nettype wire

/* tb/servo_slew_smoother_tb.sv */
`default_nettype none

module servo_slew_smoother_tb;
    import sss_pkg::*;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = REG_CHANNEL + 4'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic              wr;
        logic [CH_W-1:0]   ch;
        logic [STEP_W-1:0] steps;
        logic              settled;
    } pwm_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [POS_W-1:0]      position;
    logic                  out_valid;
    logic                  out_ready;
    logic                  pwm_write;
    logic [CH_W-1:0]       pwm_channel;
    logic [STEP_W-1:0]     pwm_steps;
    logic                  settled;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    servo_slew_smoother uut (.*);

    // shadow copy of the servo state and registers
    logic [STEP_W-1:0] lim_lo, lim_hi;
    logic              swap_lim, smooth_on, lin_on;
    logic [POS_W-1:0]  span_lo, span_hi;
    logic [CH_W-1:0]   out_chan;
    logic [STEP_W-1:0] tgt_steps, cur_steps;

    pwm_result_t expected_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    bit in_up;
    bit cfg_up;
    int errors;
    int n_set, n_tick, n_written, n_settled, n_cfg;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void shadow_reset();
        lim_lo    = RESET_MIN_STEPS;
        lim_hi    = RESET_MAX_STEPS;
        swap_lim  = 1'b0;
        smooth_on = 1'b1;
        lin_on    = 1'b1;
        span_lo   = RESET_POS_LOW;
        span_hi   = RESET_POS_HIGH;
        out_chan  = '0;
        tgt_steps = RESET_MID;
        cur_steps = RESET_MID;
    endfunction

    function automatic logic [STEP_W-1:0] steps_for_position(logic [POS_W-1:0] p);
        longint a_lo, a_hi, s_lo, s_hi, pp, v;
        a_lo = span_lo;
        a_hi = span_hi;
        s_lo = swap_lim ? lim_hi : lim_lo;
        s_hi = swap_lim ? lim_lo : lim_hi;
        pp   = p;
        // zero-width span gives the first limit outright
        if (a_hi == a_lo)
            v = s_lo;
        else
            v = (pp - a_lo) * (s_hi - s_lo) / (a_hi - a_lo) + s_lo;
        if (v < 0)
            v = 0;
        if (v > STEP_TOP)
            v = STEP_TOP;
        return v[STEP_W-1:0];
    endfunction

    function automatic pwm_result_t predict_servo(logic m, logic [POS_W-1:0] p);
        pwm_result_t r;
        int t, c, d, n;
        r    = '0;
        r.ch = out_chan;
        if (m == MODE_SET)
        begin
            if (smooth_on)
                tgt_steps = steps_for_position(p);
            else
            begin
                r.wr    = 1'b1;
                r.steps = steps_for_position(p);
            end
        end
        else if (smooth_on && tgt_steps != cur_steps)
        begin
            t = tgt_steps;
            c = cur_steps;
            d = (t > c) ? t - c : c - t;
            if (lin_on)
                n = (d > int'(LIN_SNAP)) ? ((c < t) ? c + 1 : c - 1) : t;
            else
                n = (d < int'(PROP_SNAP)) ? t : (t + 9 * c) / 10;
            cur_steps = n[STEP_W-1:0];
            r.wr      = 1'b1;
            r.steps   = cur_steps;
        end
        else
            r.settled = 1'b1;
        return r;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MIN_STEPS:     lim_lo    = d[STEP_W-1:0];
            REG_MAX_STEPS:     lim_hi    = d[STEP_W-1:0];
            REG_REVERSED:      swap_lim  = d[0];
            REG_SMOOTHED:      smooth_on = d[0];
            REG_LINEAR_MODE:   lin_on    = d[0];
            REG_POSITION_LOW:  span_lo   = d[POS_W-1:0];
            REG_POSITION_HIGH: span_hi   = d[POS_W-1:0];
            REG_CHANNEL:       out_chan  = d[CH_W-1:0];
            default:           ;
        endcase
    endfunction

    // hold the sender until the block has handed back every result
    task automatic wait_drain();
        if (in_up)
        begin
            in_valid <= 1'b0;
            in_up = 1'b0;
        end
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(logic m, logic [POS_W-1:0] p);
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        if (roll(send_idle_pct))
        begin
            if (in_up)
            begin
                in_valid <= 1'b0;
                in_up = 1'b0;
            end
            do
                @(posedge clk);
            while (roll(send_idle_pct));
        end
        in_valid <= 1'b1;
        mode     <= m;
        position <= p;
        in_up = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(predict_servo(m, p));
        if (m == MODE_SET)
            n_set++;
        else
            n_tick++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_up = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, d);
        n_cfg++;
    endtask

    // steps equal position over 0..4095
    task automatic identity_map();
        write_reg(REG_MIN_STEPS, 16'd0);
        write_reg(REG_MAX_STEPS, 16'(STEP_TOP));
        write_reg(REG_REVERSED, 16'd0);
        write_reg(REG_POSITION_LOW, 16'd0);
        write_reg(REG_POSITION_HIGH, 16'(STEP_TOP));
        write_reg(REG_SMOOTHED, 16'd1);
    endtask

    // result check and receiver stalls
    initial
    begin : result_check
        pwm_result_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pwm_write)
                    n_written++;
                if (settled)
                    n_settled++;
                if (expected_q.size() == 0)
                    note_error($sformatf("unexpected beat wr=%0b ch=%0d steps=%0d settled=%0b",
                                         pwm_write, pwm_channel, pwm_steps, settled));
                else
                begin
                    want = expected_q.pop_front();
                    if (pwm_write !== want.wr || pwm_channel !== want.ch ||
                        pwm_steps !== want.steps || settled !== want.settled)
                        note_error($sformatf({"exp wr=%0b ch=%0d steps=%0d settled=%0b, ",
                                              "got wr=%0b ch=%0d steps=%0d settled=%0b"},
                                             want.wr, want.ch, want.steps, want.settled,
                                             pwm_write, pwm_channel, pwm_steps, settled));
                end
            end
            out_ready <= !roll(recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_q.size());
        $display("servo_slew_smoother_tb: done, errors");
        $finish;
    end

    task automatic test_reset_state();
        send_item(MODE_TICK, 16'hFFFF);     // target equals current out of reset
        send_item(MODE_SET, RESET_POS_HIGH);
        send_item(MODE_TICK, 16'h0000);
    endtask

    task automatic test_map_extremes();
        write_reg(REG_SMOOTHED, 16'd0);
        write_reg(REG_CHANNEL, 16'hFFF5);
        send_item(MODE_SET, 16'h0000);
        send_item(MODE_SET, 16'hFFFF);      // saturates high
        send_item(MODE_TICK, 16'h1234);     // no smoothing: settled
        write_reg(REG_REVERSED, 16'hFFFF);
        send_item(MODE_SET, 16'd700);
        // falling slope, far position drives below zero
        write_reg(REG_REVERSED, 16'd0);
        write_reg(REG_MIN_STEPS, 16'(STEP_TOP));
        write_reg(REG_MAX_STEPS, 16'd0);
        write_reg(REG_POSITION_HIGH, 16'd1);
        send_item(MODE_SET, 16'hFFFF);
    endtask

    task automatic test_zero_span();
        write_reg(REG_POSITION_LOW, 16'd1234);
        write_reg(REG_POSITION_HIGH, 16'd1234);
        send_item(MODE_SET, 16'h0000);
        write_reg(REG_REVERSED, 16'd1);
        send_item(MODE_SET, 16'hFFFF);
        write_reg(REG_POSITION_LOW, 16'hFFFF);
        write_reg(REG_POSITION_HIGH, 16'h0000);
        send_item(MODE_SET, 16'h8000);
    endtask

    task automatic test_proportional();
        identity_map();
        write_reg(REG_LINEAR_MODE, 16'd0);
        write_reg(REG_CHANNEL, 16'd9);
        send_item(MODE_SET, 16'(cur_steps + 9));    // inside snap window
        send_item(MODE_TICK, 16'h0);
        send_item(MODE_SET, 16'(cur_steps + 10));   // just outside it
        send_item(MODE_TICK, 16'h0);
        send_item(MODE_SET, 16'(STEP_TOP));
        send_item(MODE_TICK, 16'h0);
        send_item(MODE_SET, 16'h0);
        send_item(MODE_TICK, 16'h0);
    endtask

    task automatic test_linear();
        write_reg(REG_LINEAR_MODE, 16'd1);
        send_item(MODE_SET, 16'(cur_steps + 2));
        send_item(MODE_TICK, 16'h0);
        send_item(MODE_TICK, 16'h0);        // one apart: snaps
        send_item(MODE_TICK, 16'h0);
        send_item(MODE_SET, 16'(cur_steps - 1));
        send_item(MODE_TICK, 16'h0);
    endtask

    task automatic test_spare_index();
        write_reg(IDX_SPARE_LO, 16'hFFFF);
        write_reg(IDX_SPARE_HI, 16'h0000);
        send_item(MODE_SET, 16'd50);
    endtask

    function automatic logic [STEP_W-1:0] pick_limit(logic [STEP_W-1:0] other);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return STEP_W'(STEP_TOP);
            2:       return other + STEP_W'($urandom_range(0, 15));
            3:       return other - STEP_W'($urandom_range(0, 15));
            default: return STEP_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0:         return '0;
            1:         return '1;
            2:         return span_lo;
            3:         return span_hi;
            4, 5, 6:   return POS_W'($urandom_range(span_lo, span_hi));
            default:   return POS_W'($urandom);
        endcase
    endfunction

    task automatic shuffle_config();
        logic [POS_W-1:0] a, b;
        if (roll(70))
            write_reg(REG_MIN_STEPS, {4'($urandom), pick_limit(lim_hi)});
        if (roll(70))
            write_reg(REG_MAX_STEPS, {4'($urandom), pick_limit(lim_lo)});
        if (roll(50))
            write_reg(REG_REVERSED, {15'($urandom), 1'($urandom)});
        if (roll(50))
            write_reg(REG_SMOOTHED, {15'($urandom), roll(80)});
        if (roll(60))
            write_reg(REG_LINEAR_MODE, {15'($urandom), 1'($urandom)});
        if (roll(30))
            write_reg(REG_CHANNEL, 16'($urandom));
        if (roll(10))
            write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 16'($urandom));
        if (roll(60))
        begin
            a = POS_W'($urandom);
            case ($urandom_range(0, 5))
                0:       b = a;
                1:       begin a = '0; b = '1; end
                2:       begin a = '1; b = '0; end
                3:       b = a + POS_W'($urandom_range(1, 50));
                4:       begin a = RESET_POS_LOW; b = RESET_POS_HIGH; end
                default: b = POS_W'($urandom);
            endcase
            write_reg(REG_POSITION_LOW, a);
            write_reg(REG_POSITION_HIGH, b);
        end
    endtask

    // mostly a set followed by a run of ticks; the rest is loose noise
    task automatic run_random_items(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_drain();
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(1'($urandom), POS_W'($urandom));
                sent++;
            end
            else
            begin
                send_item(MODE_SET, pick_position());
                sent++;
                repeat ($urandom_range(1, 12))
                begin
                    send_item(MODE_TICK, POS_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drain();
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                shuffle_config();
                run_random_items(64);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_SET;
        position  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_STEPS;
        cfg_data  = '0;
        in_up     = 1'b0;
        cfg_up    = 1'b0;
        errors    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        shadow_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_map_extremes();
        test_zero_span();
        test_proportional();
        test_linear();
        test_spare_index();
        test_random();

        wait_drain();
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d set and %0d tick beats over %0d register writes",
                 n_set, n_tick, n_cfg);
        $display("driver writes %0d, settled ticks %0d, mismatches %0d",
                 n_written, n_settled, errors);
        if (errors == 0)
            $display("servo_slew_smoother_tb: done, clean");
        else
            $display("servo_slew_smoother_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
